// File: hdl/lavm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_pkg
// Types, widths and constants shared by the limited-angle voxel mask unit.
// ----------------------------------------------------------------------------
package lavm_pkg;

    localparam int COL_W        = 10;
    localparam int ANG_IDX_W    = 10;
    localparam int ANGLE_W      = 18;
    localparam int SIZE_W       = 11;
    localparam int INDEX_W      = 30;
    localparam int CFG_IDX_W    = 2;
    localparam int COORD_W      = 13;
    localparam int NN_W         = 2 * SIZE_W;
    localparam int JN_W         = 22;
    localparam int PROD_W       = 32;
    localparam int CW           = 32;
    localparam int Z_W          = 18;
    localparam int WIN_W        = 20;
    localparam int PREC_SHIFT   = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int ANG_PI      = 65536;
    localparam int ANG_HALF_PI = 32768;
    localparam int ANG_WIN     = 3641;

    localparam logic [SIZE_W-1:0] RECON_SIZE_RST = 11'd512;

    localparam logic [CFG_IDX_W-1:0] CFG_RECON_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_PASS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_NEG  = 2'd2;

    typedef struct packed {
        logic [SIZE_W-1:0] recon_size;
        logic              all_pass;
        logic              scale_neg;
    } t_cfg;

    typedef struct packed {
        logic        [COL_W-1:0]     col;
        logic        [COL_W-1:0]     row;
        logic        [ANG_IDX_W-1:0] angle_index;
        logic signed [ANGLE_W-1:0]   proj_angle;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0]   px;
        logic signed [COORD_W-1:0]   py;
        logic        [NN_W-1:0]      nn;
        logic        [JN_W-1:0]      jn;
        logic        [ANG_IDX_W-1:0] k;
        logic signed [ANGLE_W-1:0]   a;
    } t_coord;

    typedef struct packed {
        logic signed [CW-1:0]      x;
        logic signed [CW-1:0]      y;
        logic signed [Z_W-1:0]     z;
        logic signed [ANGLE_W-1:0] a;
        logic        [INDEX_W-1:0] idx;
    } t_rot;

    typedef struct packed {
        logic               mask_bit;
        logic [INDEX_W-1:0] mask_index;
    } t_res;

    // round(atan(2^-s) * 65536 / pi)
    function automatic logic signed [Z_W-1:0] atan_unit(input int s);
        logic signed [Z_W-1:0] v;
        case (s)
            0:       v = 18'sd16384;
            1:       v = 18'sd9672;
            2:       v = 18'sd5110;
            3:       v = 18'sd2594;
            4:       v = 18'sd1302;
            5:       v = 18'sd652;
            6:       v = 18'sd326;
            7:       v = 18'sd163;
            8:       v = 18'sd81;
            9:       v = 18'sd41;
            10:      v = 18'sd20;
            11:      v = 18'sd10;
            12:      v = 18'sd5;
            13:      v = 18'sd3;
            14:      v = 18'sd1;
            15:      v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/lavm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_in_if
// Input item channel: pixel, projection index and projection angle.
// ----------------------------------------------------------------------------
interface lavm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic        [lavm_pkg::COL_W-1:0]     col;
    logic        [lavm_pkg::COL_W-1:0]     row;
    logic        [lavm_pkg::ANG_IDX_W-1:0] angle_index;
    logic signed [lavm_pkg::ANGLE_W-1:0]   proj_angle;

    modport source (output valid, output col, output row, output angle_index,
                    output proj_angle, input ready);
    modport sink   (input valid, input col, input row, input angle_index,
                    input proj_angle, output ready);
endinterface
`default_nettype wire

// File: hdl/lavm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_out_if
// Result item channel: mask bit and linear mask address.
// ----------------------------------------------------------------------------
interface lavm_out_if;
    logic                              valid;
    logic                              ready;
    logic                              mask_bit;
    logic [lavm_pkg::INDEX_W-1:0]      mask_index;

    modport source (output valid, output mask_bit, output mask_index, input ready);
    modport sink   (input valid, input mask_bit, input mask_index, output ready);
endinterface
`default_nettype wire

// File: hdl/lavm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_front
// Two stages: doubled pixel coordinates and address partials, then the
// quadrant pre-rotation, fixed-point scaling and final mask address.
// ----------------------------------------------------------------------------
module lavm_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  lavm_pkg::t_cfg        i_cfg,
    input  wire logic             i_vld,
    input  lavm_pkg::t_in         i_data,
    output logic                  o_rdy,
    output logic                  o_vld,
    output lavm_pkg::t_rot        o_data,
    input  wire logic             i_rdy
);

    localparam int CW      = lavm_pkg::CW;
    localparam int COORD_W = lavm_pkg::COORD_W;
    localparam int SIZE_W  = lavm_pkg::SIZE_W;

    logic                    r_a_vld;
    lavm_pkg::t_coord        r_a;
    lavm_pkg::t_coord        n_a;
    logic                    w_a_rdy;
    logic                    r_b_vld;
    lavm_pkg::t_rot          r_b;
    lavm_pkg::t_rot          n_b;

    logic        [SIZE_W-1:0]  w_half2;
    logic signed [COORD_W-1:0] w_px_raw;
    logic signed [COORD_W-1:0] w_py_raw;
    logic signed [COORD_W-1:0] w_x0;
    logic signed [COORD_W-1:0] w_y0;
    logic signed [COORD_W-1:0] w_x1;
    logic signed [COORD_W-1:0] w_y1;
    logic [lavm_pkg::PROD_W-1:0] w_addr;

    assign w_a_rdy = !r_b_vld || i_rdy;
    assign o_rdy   = !r_a_vld || w_a_rdy;

    // stage A
    assign w_half2  = {i_cfg.recon_size[SIZE_W-1:1], 1'b0};
    assign w_px_raw = $signed(COORD_W'({i_data.col, 1'b0})) - $signed(COORD_W'(w_half2))
                      + COORD_W'(1);
    assign w_py_raw = $signed(COORD_W'({i_data.row, 1'b0})) - $signed(COORD_W'(w_half2))
                      + COORD_W'(1);

    always_comb begin
        n_a.px = i_cfg.scale_neg ? -w_px_raw : w_px_raw;
        n_a.py = i_cfg.scale_neg ? w_py_raw : -w_py_raw;
        n_a.nn = lavm_pkg::NN_W'(i_cfg.recon_size) * lavm_pkg::NN_W'(i_cfg.recon_size);
        n_a.jn = lavm_pkg::JN_W'(i_data.row) * lavm_pkg::JN_W'(i_cfg.recon_size)
                 + lavm_pkg::JN_W'(i_data.col);
        n_a.k  = i_data.angle_index;
        n_a.a  = i_data.proj_angle;
    end

    // stage B: vector (py, -px), folded into the right half plane
    assign w_x0   = r_a.py;
    assign w_y0   = -r_a.px;
    assign w_addr = lavm_pkg::PROD_W'(r_a.k) * lavm_pkg::PROD_W'(r_a.nn)
                    + lavm_pkg::PROD_W'(r_a.jn);

    always_comb begin
        w_x1  = w_x0;
        w_y1  = w_y0;
        n_b.z = '0;
        if (w_x0[COORD_W-1]) begin
            if (!w_y0[COORD_W-1] && (w_y0 != '0)) begin
                w_x1  = w_y0;
                w_y1  = -w_x0;
                n_b.z = lavm_pkg::Z_W'(lavm_pkg::ANG_HALF_PI);
            end else begin
                w_x1  = -w_y0;
                w_y1  = w_x0;
                n_b.z = -lavm_pkg::Z_W'(lavm_pkg::ANG_HALF_PI);
            end
        end
        n_b.x   = CW'(w_x1) <<< lavm_pkg::PREC_SHIFT;
        n_b.y   = CW'(w_y1) <<< lavm_pkg::PREC_SHIFT;
        n_b.a   = r_a.a;
        n_b.idx = w_addr[lavm_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (o_rdy) begin
                r_a_vld <= i_vld;
            end
            if (w_a_rdy) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_a <= n_a;
        end
        if (w_a_rdy) begin
            r_b <= n_b;
        end
    end

    assign o_vld  = r_b_vld;
    assign o_data = r_b;

endmodule
`default_nettype wire

// File: hdl/lavm_cordic_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_cordic_stage
// One registered vectoring CORDIC micro-rotation.
// ----------------------------------------------------------------------------
module lavm_cordic_stage #(
    parameter int SHIFT = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_vld,
    input  lavm_pkg::t_rot i_data,
    output logic           o_rdy,
    output logic           o_vld,
    output lavm_pkg::t_rot o_data,
    input  wire logic      i_rdy
);

    localparam int CW = lavm_pkg::CW;
    localparam logic signed [lavm_pkg::Z_W-1:0] ATAN = lavm_pkg::atan_unit(SHIFT);

    logic                 r_vld;
    lavm_pkg::t_rot       r_data;
    lavm_pkg::t_rot       n_data;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic                 w_pos;

    assign o_rdy = !r_vld || i_rdy;
    assign w_dx  = i_data.y >>> SHIFT;
    assign w_dy  = i_data.x >>> SHIFT;
    assign w_pos = !i_data.y[CW-1] && (i_data.y != '0);

    always_comb begin
        n_data = i_data;
        if (w_pos) begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + ATAN;
        end else begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
`default_nettype wire

// File: hdl/lavm_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lavm_window
// Window ends from the pixel angle, single wrap, strict compares; output
// register of the unit.
// ----------------------------------------------------------------------------
module lavm_window (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  lavm_pkg::t_cfg i_cfg,
    input  wire logic      i_vld,
    input  lavm_pkg::t_rot i_data,
    output logic           o_rdy,
    output logic           o_vld,
    output lavm_pkg::t_res o_data,
    input  wire logic      i_rdy
);

    localparam int WIN_W = lavm_pkg::WIN_W;
    localparam logic signed [WIN_W-1:0] W_PI     = WIN_W'(lavm_pkg::ANG_PI);
    localparam logic signed [WIN_W-1:0] W_TWO_PI = WIN_W'(2 * lavm_pkg::ANG_PI);
    localparam logic signed [WIN_W-1:0] W_WIN    = WIN_W'(lavm_pkg::ANG_WIN);

    logic                    r_vld;
    lavm_pkg::t_res          r_data;
    lavm_pkg::t_res          n_data;
    logic signed [WIN_W-1:0] w_z;
    logic signed [WIN_W-1:0] w_a;
    logic signed [WIN_W-1:0] w_ts_raw;
    logic signed [WIN_W-1:0] w_te_raw;
    logic signed [WIN_W-1:0] w_ts;
    logic signed [WIN_W-1:0] w_te;
    logic                    w_bit;

    assign o_rdy    = !r_vld || i_rdy;
    assign w_z      = WIN_W'(i_data.z);
    assign w_a      = WIN_W'(i_data.a);
    assign w_ts_raw = w_z + W_PI - W_WIN;
    assign w_te_raw = w_z + W_WIN;

    always_comb begin
        w_ts = w_ts_raw;
        if (w_ts_raw < -W_PI) begin
            w_ts = w_ts_raw + W_TWO_PI;
        end else if (w_ts_raw > W_PI) begin
            w_ts = w_ts_raw - W_TWO_PI;
        end
        w_te = w_te_raw;
        if (w_te_raw > W_PI) begin
            w_te = w_te_raw - W_TWO_PI;
        end else if (w_te_raw < -W_PI) begin
            w_te = w_te_raw + W_TWO_PI;
        end
        if (w_ts > w_te) begin
            w_bit = ((w_a > w_ts) && (w_a < W_PI)) || ((w_a > -W_PI) && (w_a < w_te));
        end else begin
            w_bit = (w_a > w_ts) && (w_a < w_te);
        end
        n_data.mask_bit   = w_bit || i_cfg.all_pass;
        n_data.mask_index = i_data.idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
`default_nettype wire

// File: hdl/limited_angle_voxel_mask_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// limited_angle_voxel_mask_unit
// Per pixel and projection mask bit for a limited-angle window, with address.
// ----------------------------------------------------------------------------
// Takes one item per clock when the output is not stalled and returns one
// result per item, in order. Each item passes through two front stages
// (coordinates and address multiply, pre-rotation), sixteen CORDIC stages of
// one micro-rotation each, and the window compare stage that is the output
// register. Every stage moves independently, so bubbles close up under
// backpressure. Registers: 0 grid size N, 1 all-pass, 2 negative scale;
// write them only while the unit is empty.
module limited_angle_voxel_mask_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [lavm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [lavm_pkg::SIZE_W-1:0]      i_cfg_data,
    lavm_in_if.sink                               i_in,
    lavm_out_if.source                            o_out
);

    localparam int STEPS = lavm_pkg::CORDIC_STEPS;

    lavm_pkg::t_cfg r_cfg;
    lavm_pkg::t_in  w_in;
    lavm_pkg::t_res w_res;
    logic           w_in_rdy;
    logic           w_out_vld;

    logic           w_vld [0:STEPS];
    logic           w_rdy [0:STEPS];
    lavm_pkg::t_rot w_rot [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.recon_size <= lavm_pkg::RECON_SIZE_RST;
            r_cfg.all_pass   <= 1'b0;
            r_cfg.scale_neg  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lavm_pkg::CFG_RECON_SIZE: r_cfg.recon_size <= i_cfg_data;
                lavm_pkg::CFG_ALL_PASS:   r_cfg.all_pass   <= i_cfg_data[0];
                lavm_pkg::CFG_SCALE_NEG:  r_cfg.scale_neg  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_in.col         = i_in.col;
    assign w_in.row         = i_in.row;
    assign w_in.angle_index = i_in.angle_index;
    assign w_in.proj_angle  = i_in.proj_angle;
    assign i_in.ready       = w_in_rdy;

    lavm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (i_in.valid),
        .i_data  (w_in),
        .o_rdy   (w_in_rdy),
        .o_vld   (w_vld[0]),
        .o_data  (w_rot[0]),
        .i_rdy   (w_rdy[0])
    );

    for (genvar s = 0; s < STEPS; s++) begin : g_cordic
        lavm_cordic_stage #(
            .SHIFT (s)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[s]),
            .i_data  (w_rot[s]),
            .o_rdy   (w_rdy[s]),
            .o_vld   (w_vld[s+1]),
            .o_data  (w_rot[s+1]),
            .i_rdy   (w_rdy[s+1])
        );
    end

    lavm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (w_vld[STEPS]),
        .i_data  (w_rot[STEPS]),
        .o_rdy   (w_rdy[STEPS]),
        .o_vld   (w_out_vld),
        .o_data  (w_res),
        .i_rdy   (o_out.ready)
    );

    assign o_out.valid      = w_out_vld;
    assign o_out.mask_bit   = w_res.mask_bit;
    assign o_out.mask_index = w_res.mask_index;

    a_all_pass_forces_one: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_cfg.all_pass) |-> o_out.mask_bit
    ) else $error("all-pass mode gave a zero mask bit");

    a_ready_chain: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready
    ) else $error("input stalled while the output side is ready");

    a_reset_empties: assert property (
        @(posedge i_clk)
        !i_rst_n |=> !o_out.valid
    ) else $error("result valid right after reset");

endmodule
`default_nettype wire

// File: tb/sv/limited_angle_voxel_mask_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// limited_angle_voxel_mask_unit_test
// Self-checking bench for the limited-angle voxel mask unit. Drives pixel and
// projection items through the input channel under random source and sink
// stalls, predicts the mask bit (CORDIC pixel angle, wrapped window, strict
// compares) and the linear mask address, and checks every result in order.
// Register settings change between drained phases: reset values, zero and
// oversized grids, a one-pixel grid, all-pass and negative scale.
// ----------------------------------------------------------------------------
module limited_angle_voxel_mask_unit_test;

    localparam int LATENCY        = 19;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SEG_ITEMS      = 150;
    localparam int SEGMENTS       = 11;
    localparam int MAX_REPORTS    = 10;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [lavm_pkg::CFG_IDX_W-1:0] i_cfg_index = lavm_pkg::CFG_RECON_SIZE;
    logic [lavm_pkg::SIZE_W-1:0]    i_cfg_data  = '0;

    lavm_in_if  in_ch ();
    lavm_out_if out_ch ();

    limited_angle_voxel_mask_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // register copies for prediction
    logic [lavm_pkg::SIZE_W-1:0] grid_size    = lavm_pkg::RECON_SIZE_RST;
    logic                        all_pass_on  = 1'b0;
    logic                        scale_neg_on = 1'b0;

    int             src_idle_pct   = 0;
    int             snk_idle_pct   = 0;
    int             mismatch_count = 0;
    int             stall_cycles   = 0;
    lavm_pkg::t_res pending_masks[$];
    lavm_pkg::t_res oldest_mask;

    longint arc_table [lavm_pkg::CORDIC_STEPS] = '{16384, 9672, 5110, 2594, 1302, 652, 326,
                                                   163, 81, 41, 20, 10, 5, 3, 1, 1};

    logic [lavm_pkg::SIZE_W-1:0] seg_sizes [SEGMENTS] = '{11'd1024, 11'd1, 11'd2, 11'd7,
                                                          11'd512, 11'd2047, 11'd0, 11'd33,
                                                          11'd1000, 11'd1023, 11'd300};

    function automatic longint pixel_angle(input logic [lavm_pkg::COL_W-1:0] col,
                                           input logic [lavm_pkg::COL_W-1:0] row);
        longint half2, px, py, cx, cy, z, t, dx, dy;
        half2 = 2 * longint'(grid_size >> 1);
        px = 2 * longint'(col) - half2 + 1;
        py = -(2 * longint'(row) - half2 + 1);
        if (scale_neg_on) begin
            px = -px;
            py = -py;
        end
        cx = py * 65536;
        cy = -px * 65536;
        z  = 0;
        if (cx < 0) begin
            t = cx;
            if (cy > 0) begin
                cx = cy;
                cy = -t;
                z  = lavm_pkg::ANG_HALF_PI;
            end else begin
                cx = -cy;
                cy = t;
                z  = -lavm_pkg::ANG_HALF_PI;
            end
        end
        for (int s = 0; s < lavm_pkg::CORDIC_STEPS; s++) begin
            dx = cy >>> s;
            dy = cx >>> s;
            if (cy > 0) begin
                cx = cx + dx;
                cy = cy - dy;
                z  = z + arc_table[s];
            end else begin
                cx = cx - dx;
                cy = cy + dy;
                z  = z - arc_table[s];
            end
        end
        return z;
    endfunction

    function automatic void window_bounds(input logic [lavm_pkg::COL_W-1:0] col,
                                          input logic [lavm_pkg::COL_W-1:0] row,
                                          output longint ts, output longint te);
        longint th;
        th = pixel_angle(col, row);
        ts = th + lavm_pkg::ANG_PI - lavm_pkg::ANG_WIN;
        te = th + lavm_pkg::ANG_WIN;
        if (ts < -lavm_pkg::ANG_PI) ts = ts + 2 * lavm_pkg::ANG_PI;
        else if (ts > lavm_pkg::ANG_PI) ts = ts - 2 * lavm_pkg::ANG_PI;
        if (te > lavm_pkg::ANG_PI) te = te - 2 * lavm_pkg::ANG_PI;
        else if (te < -lavm_pkg::ANG_PI) te = te + 2 * lavm_pkg::ANG_PI;
    endfunction

    function automatic lavm_pkg::t_res predict_mask(input lavm_pkg::t_in it);
        longint         ts, te, a, n, addr;
        lavm_pkg::t_res r;
        window_bounds(it.col, it.row, ts, te);
        a = longint'(it.proj_angle);
        if (ts > te)
            r.mask_bit = ((a > ts) && (a < lavm_pkg::ANG_PI)) ||
                         ((a > -lavm_pkg::ANG_PI) && (a < te));
        else
            r.mask_bit = (a > ts) && (a < te);
        if (all_pass_on) r.mask_bit = 1'b1;
        n    = longint'(grid_size);
        addr = longint'(it.angle_index) * n * n + longint'(it.row) * n + longint'(it.col);
        r.mask_index = addr[lavm_pkg::INDEX_W-1:0];
        return r;
    endfunction

    // angle at a window end plus an offset, to hit the strict compares
    function automatic logic signed [lavm_pkg::ANGLE_W-1:0] edge_angle(
        input logic [lavm_pkg::COL_W-1:0] col,
        input logic [lavm_pkg::COL_W-1:0] row,
        input logic upper,
        input int offset);
        longint ts, te, v;
        window_bounds(col, row, ts, te);
        v = (upper ? te : ts) + offset;
        return v[lavm_pkg::ANGLE_W-1:0];
    endfunction

    function automatic lavm_pkg::t_in random_voxel();
        lavm_pkg::t_in it;
        int            r;
        int            lim;
        lim = ((grid_size == 0) || (grid_size > 1024)) ? 1024 : int'(grid_size);
        if ($urandom_range(99) < 80) begin
            it.col = lavm_pkg::COL_W'($urandom_range(lim - 1));
            it.row = lavm_pkg::COL_W'($urandom_range(lim - 1));
        end else begin
            it.col = lavm_pkg::COL_W'($urandom());
            it.row = lavm_pkg::COL_W'($urandom());
        end
        it.angle_index = lavm_pkg::ANG_IDX_W'($urandom());
        r = $urandom_range(99);
        if (r < 45)
            it.proj_angle = lavm_pkg::ANGLE_W'(int'($urandom_range(2 * lavm_pkg::ANG_PI))
                                               - lavm_pkg::ANG_PI);
        else if (r < 80)
            it.proj_angle = edge_angle(it.col, it.row, r[0], int'($urandom_range(4)) - 2);
        else if (r < 88)
            case ($urandom_range(2))
                0:       it.proj_angle = lavm_pkg::ANGLE_W'(lavm_pkg::ANG_PI);
                1:       it.proj_angle = lavm_pkg::ANGLE_W'(-lavm_pkg::ANG_PI);
                default: it.proj_angle = '0;
            endcase
        else
            it.proj_angle = lavm_pkg::ANGLE_W'($urandom());
        return it;
    endfunction

    task automatic send_item(input lavm_pkg::t_in it);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.col         <= it.col;
        in_ch.row         <= it.row;
        in_ch.angle_index <= it.angle_index;
        in_ch.proj_angle  <= it.proj_angle;
        @(negedge i_clk);
        while (!in_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        pending_masks.push_back(predict_mask(it));
    endtask

    task automatic send_voxel(input int col, input int row, input int k, input int a);
        lavm_pkg::t_in it;
        it.col         = lavm_pkg::COL_W'(col);
        it.row         = lavm_pkg::COL_W'(row);
        it.angle_index = lavm_pkg::ANG_IDX_W'(k);
        it.proj_angle  = lavm_pkg::ANGLE_W'(a);
        send_item(it);
    endtask

    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [lavm_pkg::SIZE_W-1:0] n, input logic ap,
                                input logic sn);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= lavm_pkg::CFG_RECON_SIZE;
        i_cfg_data  <= n;
        @(posedge i_clk);
        i_cfg_index <= lavm_pkg::CFG_ALL_PASS;
        i_cfg_data  <= lavm_pkg::SIZE_W'(ap);
        @(posedge i_clk);
        i_cfg_index <= lavm_pkg::CFG_SCALE_NEG;
        i_cfg_data  <= lavm_pkg::SIZE_W'(sn);
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        grid_size    = n;
        all_pass_on  = ap;
        scale_neg_on = sn;
    endtask

    task automatic test_reset_config();
        send_voxel(0, 0, 0, 0);
        send_voxel(1023, 1023, 1023, lavm_pkg::ANG_PI);
        send_voxel(511, 511, 1, -lavm_pkg::ANG_PI);
        send_voxel(512, 511, 2, 131071);
        send_voxel(511, 512, 3, -131072);
        send_voxel(0, 1023, 5, edge_angle(0, 1023, 1'b0, 0));
        send_voxel(0, 1023, 6, edge_angle(0, 1023, 1'b0, 1));
        send_voxel(300, 40, 7, edge_angle(300, 40, 1'b1, 0));
        send_voxel(300, 40, 8, edge_angle(300, 40, 1'b1, -1));
        send_voxel(700, 900, 9, edge_angle(700, 900, 1'b0, -1));
        send_voxel(1023, 0, 10, edge_angle(1023, 0, 1'b1, 1));
    endtask

    task automatic test_special_sizes();
        // zero grid: address is the column alone
        drain_pipeline();
        write_config(11'd0, 1'b0, 1'b0);
        send_voxel(1023, 5, 1023, 1000);
        send_voxel(0, 0, 0, -5000);
        // oversized grid, address wraps
        drain_pipeline();
        write_config(11'd2047, 1'b0, 1'b1);
        send_voxel(1023, 1023, 1023, 20000);
        send_voxel(0, 1023, 512, edge_angle(0, 1023, 1'b1, 0));
        drain_pipeline();
        write_config(11'd1, 1'b1, 1'b0);
        send_voxel(0, 0, 0, lavm_pkg::ANG_PI);
        send_voxel(1023, 1023, 1023, -131072);
        drain_pipeline();
        write_config(11'd1024, 1'b0, 1'b1);
        send_voxel(0, 1023, 1023, 0);
        send_voxel(1023, 0, 0, edge_angle(1023, 0, 1'b0, 0));
    endtask

    task automatic test_random_voxels();
        logic [lavm_pkg::SIZE_W-1:0] n;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_pipeline();
            if (seg < 4) begin
                src_idle_pct = 23;
                snk_idle_pct = 73;
            end else if (seg < 8) begin
                src_idle_pct = 73;
                snk_idle_pct = 23;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            n = (seg == SEGMENTS - 1) ? lavm_pkg::SIZE_W'($urandom_range(1024, 1))
                                      : seg_sizes[seg];
            write_config(n, (seg == 3) || (seg == 8), seg[0]);
            repeat (SEG_ITEMS) send_item(random_voxel());
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_masks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected item: mask_bit %0d mask_index %0d",
                             out_ch.mask_bit, out_ch.mask_index);
            end else begin
                oldest_mask = pending_masks.pop_front();
                if ((oldest_mask.mask_bit !== out_ch.mask_bit) ||
                    (oldest_mask.mask_index !== out_ch.mask_index)) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: mask_bit exp %0d got %0d, mask_index exp %0d got %0d",
                                 oldest_mask.mask_bit, out_ch.mask_bit,
                                 oldest_mask.mask_index, out_ch.mask_index);
                end
            end
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.col         = '0;
        in_ch.row         = '0;
        in_ch.angle_index = '0;
        in_ch.proj_angle  = '0;
        src_idle_pct      = 23;
        snk_idle_pct      = 73;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_config();
        test_special_sizes();
        test_random_voxels();
        drain_pipeline();
        if ((mismatch_count == 0) && (pending_masks.size() == 0))
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lavm_pkg.sv
hdl/lavm_in_if.sv
hdl/lavm_out_if.sv
hdl/lavm_front.sv
hdl/lavm_cordic_stage.sv
hdl/lavm_window.sv
hdl/limited_angle_voxel_mask_unit.sv
tb/sv/limited_angle_voxel_mask_unit_test.sv
